// ===== rtl/core/mklf_pkg.sv =====
package mklf_pkg;

    // Default sizes of the block.
    localparam int NUM_KEYWORDS_DEF    = 8;
    localparam int MAX_PATTERN_LEN_DEF = 16;
    localparam int LINE_BUFFER_LEN_DEF = 1024;

    // Fixed widths of the item fields.
    localparam int KIND_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int SLOT_W     = 3;
    localparam int POS_W      = 4;
    localparam int PLEN_W     = 5;
    localparam int LINE_LEN_W = 10;

    localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;

    typedef enum logic [KIND_W-1:0] {
        KIND_TEXT    = 2'd0,
        KIND_KW_BYTE = 2'd1,
        KIND_KW_LEN  = 2'd2
    } kind_t;

    // Write request from the item stage to the keyword store.
    typedef struct packed {
        logic                byte_en;
        logic                len_en;
        logic [SLOT_W-1:0]   slot;
        logic [POS_W-1:0]    position;
        logic [PLEN_W-1:0]   length;
        logic [BYTE_W-1:0]   value;
    } kw_wr_t;

endpackage

// ===== rtl/core/mklf_kw_store.sv =====
module mklf_kw_store #(
    parameter int NUM_KEYWORDS    = mklf_pkg::NUM_KEYWORDS_DEF,
    parameter int MAX_PATTERN_LEN = mklf_pkg::MAX_PATTERN_LEN_DEF
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  mklf_pkg::kw_wr_t                                 wr,
    output logic [NUM_KEYWORDS-1:0][MAX_PATTERN_LEN-1:0][7:0] kw_bytes,
    output logic [NUM_KEYWORDS-1:0][$clog2(MAX_PATTERN_LEN+1)-1:0] kw_lens
);

    localparam int SW = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
    localparam int PW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
    localparam int LW = $clog2(MAX_PATTERN_LEN + 1);
    localparam int SXW = SW + mklf_pkg::SLOT_W;
    localparam int PXW = PW + mklf_pkg::POS_W;
    localparam int LXW = 7;

    logic [NUM_KEYWORDS-1:0][MAX_PATTERN_LEN-1:0][7:0] bytes_reg;
    logic [NUM_KEYWORDS-1:0][LW-1:0]                   lens_reg;

    logic [SXW-1:0] slot_ext;
    logic [PXW-1:0] pos_ext;
    logic [LXW-1:0] len_ext;
    logic [LXW-1:0] len_sat;
    logic           slot_ok;
    logic           pos_ok;

    always_comb
    begin
        slot_ext = {{SW{1'b0}}, wr.slot};
        pos_ext  = {{PW{1'b0}}, wr.position};
        len_ext  = {{(LXW - mklf_pkg::PLEN_W){1'b0}}, wr.length};
        slot_ok  = slot_ext < SXW'(NUM_KEYWORDS);
        pos_ok   = pos_ext < PXW'(MAX_PATTERN_LEN);
        // Lengths above the window depth saturate.
        len_sat  = (len_ext > LXW'(MAX_PATTERN_LEN)) ? LXW'(MAX_PATTERN_LEN) : len_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg <= '0;
            lens_reg  <= '0;
        end
        else
        begin
            if (wr.byte_en && slot_ok && pos_ok)
            begin
                bytes_reg[slot_ext[SW-1:0]][pos_ext[PW-1:0]] <= wr.value;
            end
            if (wr.len_en && slot_ok)
            begin
                lens_reg[slot_ext[SW-1:0]] <= LW'(len_sat);
            end
        end
    end

    assign kw_bytes = bytes_reg;
    assign kw_lens  = lens_reg;

endmodule

// ===== rtl/core/mklf_matcher.sv =====
module mklf_matcher #(
    parameter int NUM_KEYWORDS    = mklf_pkg::NUM_KEYWORDS_DEF,
    parameter int MAX_PATTERN_LEN = mklf_pkg::MAX_PATTERN_LEN_DEF,
    parameter int LINE_BUFFER_LEN = mklf_pkg::LINE_BUFFER_LEN_DEF
) (
    input  logic [NUM_KEYWORDS-1:0][MAX_PATTERN_LEN-1:0][7:0]       kw_bytes,
    input  logic [NUM_KEYWORDS-1:0][$clog2(MAX_PATTERN_LEN+1)-1:0]  kw_lens,
    input  logic [MAX_PATTERN_LEN-1:0][7:0]                         window,
    input  logic [$clog2(LINE_BUFFER_LEN)-1:0]                      count,
    output logic                                                    any_hit,
    output logic [((NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1)-1:0] first_slot
);

    localparam int SW   = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
    localparam int PW   = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
    localparam int LW   = $clog2(MAX_PATTERN_LEN + 1);
    localparam int CW   = $clog2(LINE_BUFFER_LEN);
    localparam int CMPW = CW + LW;

    logic [NUM_KEYWORDS-1:0] slot_hit;

    // ASCII upper-case letters compare equal to their lower-case forms.
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    // Keyword byte p lines up with the window byte that arrived len-1-p bytes ago.
    always_comb
    begin
        logic [LW-1:0] tap;
        tap = '0;
        for (int s = 0; s < NUM_KEYWORDS; s++)
        begin
            slot_hit[s] = (kw_lens[s] != '0) && (CMPW'(kw_lens[s]) <= CMPW'(count));
            for (int p = 0; p < MAX_PATTERN_LEN; p++)
            begin
                if (LW'(p) < kw_lens[s])
                begin
                    tap = kw_lens[s] - LW'(p) - LW'(1);
                    if (fold_case(kw_bytes[s][p]) != fold_case(window[tap[PW-1:0]]))
                    begin
                        slot_hit[s] = 1'b0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        any_hit    = |slot_hit;
        first_slot = '0;
        for (int s = NUM_KEYWORDS - 1; s >= 0; s--)
        begin
            if (slot_hit[s])
            begin
                first_slot = SW'(s);
            end
        end
    end

endmodule

// ===== rtl/core/multi_keyword_line_filter_top.sv =====
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+---------------------------------------------
// in      | to block  | in_valid, in_ready | kind, byte_value, slot, position,
//         |           |                    | pattern_length, end_of_text
// out     | from block| out_valid,out_ready| keep_line, line_length, matched_slot
//
// The block takes one item in every cycle, unless a line-closing item waits on a held
// result. The item register feeds the compare logic, and the result register takes its
// outcome when the item that closes its line advances.
// All keyword slots are compared against the byte window in parallel.
// Reset is asynchronous and clears the keywords, the byte window and the line state.
// A stalled result blocks input only when the waiting item would close another line.
module multi_keyword_line_filter_top #(
    parameter int NUM_KEYWORDS    = mklf_pkg::NUM_KEYWORDS_DEF,
    parameter int MAX_PATTERN_LEN = mklf_pkg::MAX_PATTERN_LEN_DEF,
    parameter int LINE_BUFFER_LEN = mklf_pkg::LINE_BUFFER_LEN_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [mklf_pkg::KIND_W-1:0]          kind,
    input  logic [mklf_pkg::BYTE_W-1:0]          byte_value,
    input  logic [mklf_pkg::SLOT_W-1:0]          slot,
    input  logic [mklf_pkg::POS_W-1:0]           position,
    input  logic [mklf_pkg::PLEN_W-1:0]          pattern_length,
    input  logic                                 end_of_text,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 keep_line,
    output logic [mklf_pkg::LINE_LEN_W-1:0]      line_length,
    output logic [mklf_pkg::SLOT_W-1:0]          matched_slot
);

    localparam int SW = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
    localparam int LW = $clog2(MAX_PATTERN_LEN + 1);
    localparam int CW = $clog2(LINE_BUFFER_LEN);

    // Item register: holds the accepted item until it is processed.
    logic                               item_valid_reg;
    logic [mklf_pkg::KIND_W-1:0]        kind_reg;
    logic [mklf_pkg::BYTE_W-1:0]        byte_reg;
    logic [mklf_pkg::SLOT_W-1:0]        slot_reg;
    logic [mklf_pkg::POS_W-1:0]         pos_reg;
    logic [mklf_pkg::PLEN_W-1:0]        plen_reg;
    logic                               eot_reg;

    // Line state and the window of recent text bytes, newest in entry 0.
    logic [MAX_PATTERN_LEN-1:0][7:0]    window_reg;
    logic [MAX_PATTERN_LEN-1:0][7:0]    window_next;
    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;
    logic                               hit_reg;
    logic                               hit_next;
    logic [SW-1:0]                      first_reg;
    logic [SW-1:0]                      first_next;

    // Result register.
    logic                               out_valid_reg;
    logic                               keep_reg;
    logic [mklf_pkg::LINE_LEN_W-1:0]    length_reg;
    logic [mklf_pkg::SLOT_W-1:0]        mslot_reg;

    logic                               is_text;
    logic                               line_end;
    logic                               advance;
    logic                               any_hit;
    logic [SW-1:0]                      hit_slot;
    logic [CW+mklf_pkg::LINE_LEN_W-1:0] count_ext;
    logic [SW+mklf_pkg::SLOT_W-1:0]     first_ext;
    mklf_pkg::kw_wr_t                   kw_wr;

    logic [NUM_KEYWORDS-1:0][MAX_PATTERN_LEN-1:0][7:0] kw_bytes;
    logic [NUM_KEYWORDS-1:0][LW-1:0]                   kw_lens;

    // The count cannot wrap: a line is closed before it reaches LINE_BUFFER_LEN-1.
    always_comb
    begin
        is_text    = kind_reg == mklf_pkg::KIND_TEXT;
        count_next = count_reg + CW'(1);
        line_end   = is_text && ((byte_reg == mklf_pkg::NEWLINE_CHAR) || eot_reg
                     || (count_next >= CW'(LINE_BUFFER_LEN - 1)));
        // A line-closing item waits only while the previous result is still held.
        advance    = item_valid_reg && (!line_end || !out_valid_reg || out_ready);

        window_next[0] = byte_reg;
        for (int i = 1; i < MAX_PATTERN_LEN; i++)
        begin
            window_next[i] = window_reg[i - 1];
        end

        // The lowest slot seen anywhere in the line wins, not the earliest one.
        hit_next   = hit_reg || any_hit;
        first_next = first_reg;
        if (any_hit && (!hit_reg || (hit_slot < first_reg)))
        begin
            first_next = hit_slot;
        end

        count_ext = {{mklf_pkg::LINE_LEN_W{1'b0}}, count_next};
        first_ext = {{mklf_pkg::SLOT_W{1'b0}}, first_next};

        kw_wr.byte_en  = advance && (kind_reg == mklf_pkg::KIND_KW_BYTE);
        kw_wr.len_en   = advance && (kind_reg == mklf_pkg::KIND_KW_LEN);
        kw_wr.slot     = slot_reg;
        kw_wr.position = pos_reg;
        kw_wr.length   = plen_reg;
        kw_wr.value    = byte_reg;
    end

    assign in_ready = !item_valid_reg || advance;

    mklf_kw_store #(
        .NUM_KEYWORDS    (NUM_KEYWORDS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_kw_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (kw_wr),
        .kw_bytes (kw_bytes),
        .kw_lens  (kw_lens)
    );

    mklf_matcher #(
        .NUM_KEYWORDS    (NUM_KEYWORDS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
        .LINE_BUFFER_LEN (LINE_BUFFER_LEN)
    ) u_matcher (
        .kw_bytes   (kw_bytes),
        .kw_lens    (kw_lens),
        .window     (window_next),
        .count      (count_next),
        .any_hit    (any_hit),
        .first_slot (hit_slot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            kind_reg <= kind;
            byte_reg <= byte_value;
            slot_reg <= slot;
            pos_reg  <= position;
            plen_reg <= pattern_length;
            eot_reg  <= end_of_text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
            hit_reg    <= 1'b0;
            first_reg  <= '0;
        end
        else if (advance && is_text)
        begin
            window_reg <= window_next;
            if (line_end)
            begin
                count_reg <= '0;
                hit_reg   <= 1'b0;
                first_reg <= '0;
            end
            else
            begin
                count_reg <= count_next;
                hit_reg   <= hit_next;
                first_reg <= first_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && line_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && line_end)
        begin
            keep_reg   <= hit_next;
            length_reg <= count_ext[mklf_pkg::LINE_LEN_W-1:0];
            mslot_reg  <= hit_next ? first_ext[mklf_pkg::SLOT_W-1:0] : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign keep_line    = keep_reg;
    assign line_length  = length_reg;
    assign matched_slot = mslot_reg;

    // A new result is loaded only when the result register is free or being emptied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && line_end) |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while held");

    // The open line never reaches the forced break length.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CW'(LINE_BUFFER_LEN - 1))
        else $error("line count passed the break length");

    // Without a hit the first slot stays at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        !hit_reg |-> (first_reg == '0))
        else $error("first slot set without a hit");

    // A line without a keyword reports slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !keep_line) |-> (matched_slot == '0))
        else $error("slot reported for a line without a match");

endmodule

// ===== tb/mklf_line_checker.sv =====
`timescale 1ns / 100ps
// Watches both channels of the line filter. It keeps its own copy of the
// keyword store, the byte window and the open line, and queues one verdict for
// every line that an accepted item closes. Results are compared in order.
module mklf_line_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [mklf_pkg::KIND_W-1:0]       kind,
    input  logic [mklf_pkg::BYTE_W-1:0]       byte_value,
    input  logic [mklf_pkg::SLOT_W-1:0]       slot,
    input  logic [mklf_pkg::POS_W-1:0]        position,
    input  logic [mklf_pkg::PLEN_W-1:0]       pattern_length,
    input  logic                              end_of_text,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic                              keep_line,
    input  logic [mklf_pkg::LINE_LEN_W-1:0]   line_length,
    input  logic [mklf_pkg::SLOT_W-1:0]       matched_slot,
    output int                                mismatches,
    output int                                lines_pending
);

    localparam int SLOTS       = mklf_pkg::NUM_KEYWORDS_DEF;
    localparam int MAX_LEN     = mklf_pkg::MAX_PATTERN_LEN_DEF;
    localparam int CHUNK_LIMIT = mklf_pkg::LINE_BUFFER_LEN_DEF - 1;
    localparam int REPORT_MAX  = 10;
    localparam int LEN_W       = mklf_pkg::LINE_LEN_W;
    localparam int SEL_W       = mklf_pkg::SLOT_W;
    localparam int WLEN_W      = mklf_pkg::PLEN_W;

    typedef struct packed {
        logic                              keep;
        logic [mklf_pkg::LINE_LEN_W-1:0]   length;
        logic [mklf_pkg::SLOT_W-1:0]       slot;
    } line_verdict_t;

    logic [mklf_pkg::BYTE_W-1:0] word_bytes [SLOTS][MAX_LEN];
    logic [mklf_pkg::PLEN_W-1:0] word_lengths [SLOTS];
    logic [mklf_pkg::BYTE_W-1:0] recent_window [MAX_LEN];
    int unsigned                 bytes_in_line;
    logic                        line_hit;
    logic [mklf_pkg::SLOT_W-1:0] best_slot;
    line_verdict_t               lines_due [$];

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return c + 8'h20;
        return c;
    endfunction

    // True when slot s lies wholly inside the open line and ends at the newest byte.
    function automatic bit word_ends_here(input int s);
        int len;
        bit hit;
        len = word_lengths[s];
        hit = (len != 0) && (len <= bytes_in_line);
        if (hit)
            for (int p = 0; p < len; p++)
                if (to_lower(word_bytes[s][p]) != to_lower(recent_window[len - 1 - p]))
                    hit = 1'b0;
        return hit;
    endfunction

    task automatic fold_into_line(
        input logic [mklf_pkg::KIND_W-1:0] k,
        input logic [mklf_pkg::BYTE_W-1:0] v,
        input logic [mklf_pkg::SLOT_W-1:0] s,
        input logic [mklf_pkg::POS_W-1:0]  p,
        input logic [mklf_pkg::PLEN_W-1:0] l,
        input logic                        e
    );
        line_verdict_t done;
        bit            found;
        int            w;
        case (k)
            mklf_pkg::KIND_KW_BYTE:
                if (s < SLOTS && p < MAX_LEN)
                    word_bytes[s][p] = v;
            mklf_pkg::KIND_KW_LEN:
                if (s < SLOTS)
                    word_lengths[s] = (l > MAX_LEN) ? WLEN_W'(MAX_LEN) : l;
            mklf_pkg::KIND_TEXT:
            begin
                for (w = MAX_LEN - 1; w > 0; w--)
                    recent_window[w] = recent_window[w - 1];
                recent_window[0] = v;
                bytes_in_line++;
                found = 1'b0;
                for (w = 0; w < SLOTS; w++)
                    if (!found && word_ends_here(w))
                    begin
                        if (!line_hit || w < best_slot)
                            best_slot = SEL_W'(w);
                        line_hit = 1'b1;
                        found    = 1'b1;
                    end
                if (v == mklf_pkg::NEWLINE_CHAR || e || bytes_in_line >= CHUNK_LIMIT)
                begin
                    done.keep   = line_hit;
                    done.length = LEN_W'(bytes_in_line);
                    done.slot   = line_hit ? best_slot : '0;
                    lines_due.push_back(done);
                    bytes_in_line = 0;
                    line_hit      = 1'b0;
                    best_slot     = '0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic note_fault(input string what, input line_verdict_t want);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("[%0t] %s: expected keep=%0b len=%0d slot=%0d, got keep=%0b len=%0d slot=%0d",
                     $time, what, want.keep, want.length, want.slot,
                     keep_line, line_length, matched_slot);
    endtask

    task automatic check_line_result();
        line_verdict_t want;
        if (lines_due.size() == 0)
        begin
            want = '0;
            note_fault("result with no line pending", want);
        end
        else
        begin
            want = lines_due.pop_front();
            if (keep_line !== want.keep || line_length !== want.length
                || matched_slot !== want.slot)
                note_fault("line result mismatch", want);
        end
    endtask

    initial mismatches = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                word_lengths[s] = '0;
                for (int p = 0; p < MAX_LEN; p++)
                    word_bytes[s][p] = '0;
            end
            for (int p = 0; p < MAX_LEN; p++)
                recent_window[p] = '0;
            bytes_in_line = 0;
            line_hit      = 1'b0;
            best_slot     = '0;
            lines_due.delete();
            lines_pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_line_result();
            if (in_valid && in_ready)
                fold_into_line(kind, byte_value, slot, position, pattern_length, end_of_text);
            lines_pending <= lines_due.size();
        end
    end

endmodule

// ===== tb/multi_keyword_line_filter_top_tb.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for the keyword line filter. The checker instance beside
// the block does all prediction and comparison; this module only feeds items,
// throttles the result side and decides the outcome.
module multi_keyword_line_filter_top_tb;

    localparam int KIND_W     = mklf_pkg::KIND_W;
    localparam int BYTE_W     = mklf_pkg::BYTE_W;
    localparam int SLOT_W     = mklf_pkg::SLOT_W;
    localparam int POS_W      = mklf_pkg::POS_W;
    localparam int PLEN_W     = mklf_pkg::PLEN_W;
    localparam int LINE_LEN_W = mklf_pkg::LINE_LEN_W;

    localparam int SLOTS            = mklf_pkg::NUM_KEYWORDS_DEF;
    localparam int KW_MAX           = mklf_pkg::MAX_PATTERN_LEN_DEF;
    localparam int RANDOM_ITEMS     = 350;
    localparam int IDLE_FREE_FROM   = 60;
    localparam int IDLE_FREE_TO     = 120;
    localparam int HOLD_AT          = 150;
    localparam int HOLD_LINES       = 60;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int OVERLONG_LINE    = 1030;
    localparam int DRAIN_CYCLES     = 20;
    localparam int CYCLE_LIMIT      = 500000;

    // Kind code that the block has no use for; such items must be ignored.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // How a generated line is closed.
    localparam int LINE_NEWLINE = 0;
    localparam int LINE_EOT     = 1;
    localparam int LINE_OPEN    = 2;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  in_valid       = 1'b0;
    logic [KIND_W-1:0]     kind           = mklf_pkg::KIND_TEXT;
    logic [BYTE_W-1:0]     byte_value     = '0;
    logic [SLOT_W-1:0]     slot           = '0;
    logic [POS_W-1:0]      position       = '0;
    logic [PLEN_W-1:0]     pattern_length = '0;
    logic                  end_of_text    = 1'b0;
    logic                  out_ready      = 1'b0;
    logic                  in_ready;
    logic                  out_valid;
    logic                  keep_line;
    logic [LINE_LEN_W-1:0] line_length;
    logic [SLOT_W-1:0]     matched_slot;
    int                    mismatches;
    int                    lines_pending;

    // The keywords as loaded so far, kept only so that text can quote them.
    logic [BYTE_W-1:0] loaded_words [SLOTS][KW_MAX];
    int                loaded_sizes [SLOTS];

    int items_sent      = 0;
    int cycles          = 0;
    bit no_idle         = 1'b0;
    bit start_long_hold = 1'b0;
    bit long_hold_done  = 1'b0;

    multi_keyword_line_filter_top dut (.*);

    mklf_line_checker line_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Text bytes lean heavily on a few letters so that keywords turn up often.
    // The characters either side of the letter ranges are mixed in as well,
    // since case folding must leave them alone.
    function automatic logic [7:0] rand_char();
        int          r;
        logic [7:0]  c;
        r = $urandom_range(0, 99);
        if (r < 65)
            c = 8'h61 + 8'($urandom_range(0, 2));
        else if (r < 80)
            c = 8'h61 + 8'($urandom_range(0, 25));
        else if (r < 88)
            case ($urandom_range(0, 3))
                0:       c = 8'h40;
                1:       c = 8'h5B;
                2:       c = 8'h60;
                default: c = 8'h7B;
            endcase
        else
            c = 8'($urandom_range(0, 255));
        if (r < 80 && $urandom_range(0, 1) == 1)
            c = c ^ 8'h20;
        if (c == mklf_pkg::NEWLINE_CHAR)
            c = 8'h0B;
        return c;
    endfunction

    // Offers one item after an optional gap and holds it until it is taken.
    // Called at a rising edge; returns at the edge at which the item was accepted.
    task automatic send_item(
        input logic [KIND_W-1:0] k,
        input logic [BYTE_W-1:0] v,
        input logic [SLOT_W-1:0] s,
        input logic [POS_W-1:0]  p,
        input logic [PLEN_W-1:0] l,
        input logic              e
    );
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        kind           <= k;
        byte_value     <= v;
        slot           <= s;
        position       <= p;
        pattern_length <= l;
        end_of_text    <= e;
        do
            @(posedge clk);
        while (!in_ready);
        if (k != KIND_UNUSED)
            items_sent++;
    endtask

    // The fields that a given kind does not use are filled with junk throughout.
    task automatic send_text(input logic [BYTE_W-1:0] v, input logic e);
        send_item(mklf_pkg::KIND_TEXT, v, SLOT_W'($urandom), POS_W'($urandom),
                  PLEN_W'($urandom), e);
    endtask

    task automatic write_word_byte(input int s, input int p, input logic [BYTE_W-1:0] v);
        loaded_words[s][p] = v;
        send_item(mklf_pkg::KIND_KW_BYTE, v, SLOT_W'(s), POS_W'(p), PLEN_W'($urandom),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic write_word_length(input int s, input int l);
        loaded_sizes[s] = (l > KW_MAX) ? KW_MAX : l;
        send_item(mklf_pkg::KIND_KW_LEN, BYTE_W'($urandom), SLOT_W'(s), POS_W'($urandom),
                  PLEN_W'(l), 1'($urandom_range(0, 1)));
    endtask

    // Loads a fresh keyword into a slot. Lengths beyond the store's size are
    // written now and then, and so is zero, which switches the slot off.
    task automatic load_keyword(input int s);
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 8)
            n = 0;
        else if (r < 70)
            n = $urandom_range(1, 4);
        else if (r < 90)
            n = $urandom_range(5, KW_MAX);
        else
            n = $urandom_range(KW_MAX + 1, 31);
        for (int p = 0; p < n && p < KW_MAX; p++)
            write_word_byte(s, p, rand_char());
        write_word_length(s, n);
    endtask

    // Sends a line of random text with keywords quoted in it at random case.
    // Occasionally a keyword is reloaded while the line is still open.
    task automatic send_line(input int body, input int ending);
        int          n;
        int          s;
        logic [7:0]  c;
        n = 0;
        while (n < body)
        begin
            if ($urandom_range(0, 99) == 0)
                load_keyword($urandom_range(0, SLOTS - 1));
            else if ($urandom_range(0, 99) < 15)
            begin
                s = $urandom_range(0, SLOTS - 1);
                for (int p = 0; p < loaded_sizes[s]; p++)
                begin
                    c = loaded_words[s][p];
                    if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
                        && $urandom_range(0, 1) == 1)
                        c = c ^ 8'h20;
                    send_text(c, 1'b0);
                    n++;
                end
            end
            else
            begin
                send_text(rand_char(), 1'b0);
                n++;
            end
        end
        case (ending)
            LINE_NEWLINE: send_text(mklf_pkg::NEWLINE_CHAR, $urandom_range(0, 9) == 0);
            LINE_EOT:     send_text(rand_char(), 1'b1);
            default:      ;
        endcase
    endtask

    // An item with every field random, the unused kind included.
    task automatic send_noise();
        send_item(KIND_W'($urandom_range(0, 3)), BYTE_W'($urandom), SLOT_W'($urandom),
                  POS_W'($urandom), PLEN_W'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // The sender stops offering and waits until every closed line has been
    // reported. The pending count is registered, hence the first wait.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (lines_pending != 0)
            @(posedge clk);
    endtask

    // Result side: bursts of readiness broken by stalls, and once a long
    // hold-off so that the block backs up into its input.
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (start_long_hold && !long_hold_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else
            begin
                stall = no_idle ? 0 : pick_gap();
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Guards against a hang anywhere in the run.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int r;
        int body;
        int ending;

        for (int s = 0; s < SLOTS; s++)
        begin
            loaded_sizes[s] = 0;
            for (int p = 0; p < KW_MAX; p++)
                loaded_words[s][p] = '0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An item of the unused kind carrying a newline and an
        // end mark must leave no trace.
        send_item(KIND_UNUSED, mklf_pkg::NEWLINE_CHAR, 3'd7, 4'd15, 5'd31, 1'b1);
        // A line holding nothing but its newline.
        send_text(mklf_pkg::NEWLINE_CHAR, 1'b0);
        // Mixed-case keyword in slot 6 and a keyword of one zero byte in slot 1.
        write_word_byte(6, 0, "a");
        write_word_byte(6, 1, "B");
        write_word_length(6, 2);
        write_word_byte(1, 0, 8'h00);
        write_word_length(1, 1);
        // Slot 6 matches first in time, slot 1 later on the zero byte; the
        // lower slot must be reported. The end mark closes the line.
        send_text("x", 1'b0);
        send_text("A", 1'b0);
        send_text("b", 1'b0);
        send_text(8'h00, 1'b1);
        // Slot 6 is switched off between the two halves of its keyword.
        send_text("a", 1'b0);
        write_word_length(6, 0);
        send_text("B", 1'b0);
        send_text(mklf_pkg::NEWLINE_CHAR, 1'b0);
        // A keyword that spans a newline must never match across two lines.
        write_word_byte(6, 1, mklf_pkg::NEWLINE_CHAR);
        write_word_byte(6, 2, "b");
        write_word_length(6, 3);
        send_text("a", 1'b0);
        send_text(mklf_pkg::NEWLINE_CHAR, 1'b0);
        send_text("b", 1'b0);
        send_text(mklf_pkg::NEWLINE_CHAR, 1'b0);
        // Top byte value, closed by the end mark.
        send_text(8'hFF, 1'b1);

        wait_for_results();

        // Random part: mostly well-formed lines against a changing keyword set.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (!start_long_hold && items_sent >= HOLD_AT)
            begin
                // Short lines offered back to back while the result side holds
                // off, until the block stops taking items.
                start_long_hold = 1'b1;
                no_idle         = 1'b1;
                repeat (HOLD_LINES)
                    send_line($urandom_range(1, 3), LINE_NEWLINE);
                no_idle = 1'b0;
                wait_for_results();
            end
            else
            begin
                no_idle = items_sent >= IDLE_FREE_FROM && items_sent < IDLE_FREE_TO;
                r = $urandom_range(0, 99);
                if (r < 10)
                    load_keyword($urandom_range(0, SLOTS - 1));
                else if (r < 85)
                begin
                    body   = ($urandom_range(0, 9) == 0) ? $urandom_range(26, 90)
                                                         : $urandom_range(0, 25);
                    r      = $urandom_range(0, 99);
                    ending = (r < 70) ? LINE_NEWLINE : (r < 85) ? LINE_EOT : LINE_OPEN;
                    send_line(body, ending);
                end
                else
                    send_noise();
            end
        end

        // One line longer than the line buffer, which the block must cut.
        send_line(OVERLONG_LINE, LINE_NEWLINE);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && lines_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
